>>> hw/rtl/spiee_pkg.sv
// Shared types, codes and the result expansion table of the SPI EEPROM sequencer.
`default_nettype none
package spiee_pkg;

  localparam int ADDR_W = 24;
  localparam int LEN_W  = 18;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // SPI opcodes
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_WRDI  = 8'h04;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_WRITE = 8'h02;
  localparam logic [7:0] OP_READ  = 8'h03;

  // done / reject status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_ORDER     = 2'd2;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_WDATA  = 2'd2,
    REQ_RXBYTE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READ  = 2'd1,
    PH_WDATA = 2'd2,
    PH_POLL  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    K_SEND = 3'd0,
    K_RECV = 3'd1,
    K_REL  = 3'd2,
    K_HOST = 3'd3,
    K_DONE = 3'd4
  } kind_t;

  // Result sequences the front hands to the back
  typedef enum logic [3:0] {
    SEQ_REJECT      = 4'd0,
    SEQ_READ        = 4'd1,
    SEQ_READ_ZERO   = 4'd2,
    SEQ_FINISH      = 4'd3,
    SEQ_CHUNK       = 4'd4,
    SEQ_DATA        = 4'd5,
    SEQ_DATA_END    = 4'd6,
    SEQ_HOST_MORE   = 4'd7,
    SEQ_HOST_END    = 4'd8,
    SEQ_POLL_BUSY   = 4'd9,
    SEQ_POLL_CHUNK  = 4'd10,
    SEQ_POLL_FINISH = 4'd11
  } seq_t;

  typedef struct packed {
    seq_t              seq;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        dbyte;
    logic [1:0]        status;
  } cmd_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [1:0] status;
    logic       last;
  } res_t;

  function automatic res_t mk_res(kind_t k, logic [7:0] v, logic l);
    res_t r;
    r.kind   = k;
    r.value  = v;
    r.status = ST_OK;
    r.last   = l;
    return r;
  endfunction

  // Address byte, most significant first: sel 0 high, 1 middle, 2 low
  function automatic logic [7:0] addr_byte(logic [ADDR_W-1:0] a, logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = a[23:16];
      2'd1:    b = a[15:8];
      default: b = a[7:0];
    endcase
    return b;
  endfunction

  // Read header: opcode then three address bytes
  function automatic res_t read_hdr(logic [ADDR_W-1:0] a, logic [2:0] s);
    res_t r;
    if (s == 3'd0) begin
      r = mk_res(K_SEND, OP_READ, 1'b0);
    end else begin
      r = mk_res(K_SEND, addr_byte(a, 2'(s - 3'd1)), 1'b0);
    end
    return r;
  endfunction

  // Chunk start: write enable, release, write opcode, address
  function automatic res_t chunk_res(logic [ADDR_W-1:0] a, logic [2:0] s);
    res_t r;
    case (s)
      3'd0:    r = mk_res(K_SEND, OP_WREN, 1'b0);
      3'd1:    r = mk_res(K_REL, 8'd0, 1'b0);
      3'd2:    r = mk_res(K_SEND, OP_WRITE, 1'b0);
      3'd3:    r = mk_res(K_SEND, addr_byte(a, 2'd0), 1'b0);
      3'd4:    r = mk_res(K_SEND, addr_byte(a, 2'd1), 1'b0);
      default: r = mk_res(K_SEND, addr_byte(a, 2'd2), 1'b1);
    endcase
    return r;
  endfunction

  // Write end: write disable, release, done
  function automatic res_t finish_res(logic [2:0] s);
    res_t r;
    case (s)
      3'd0:    r = mk_res(K_SEND, OP_WRDI, 1'b0);
      3'd1:    r = mk_res(K_REL, 8'd0, 1'b0);
      default: r = mk_res(K_DONE, 8'd0, 1'b1);
    endcase
    return r;
  endfunction

  // Result number s of a command
  function automatic res_t cmd_result(cmd_t c, logic [2:0] s);
    res_t       r;
    logic [2:0] s1;
    s1 = s - 3'd1;
    r  = mk_res(K_DONE, 8'd0, 1'b1);
    case (c.seq)
      SEQ_REJECT: begin
        r.status = c.status;
      end
      SEQ_READ: begin
        if (s < 3'd4) r = read_hdr(c.addr, s);
        else          r = mk_res(K_RECV, 8'd0, 1'b1);
      end
      SEQ_READ_ZERO: begin
        if (s < 3'd4)       r = read_hdr(c.addr, s);
        else if (s == 3'd4) r = mk_res(K_REL, 8'd0, 1'b0);
        else                r = mk_res(K_DONE, 8'd0, 1'b1);
      end
      SEQ_FINISH: r = finish_res(s);
      SEQ_CHUNK:  r = chunk_res(c.addr, s);
      SEQ_DATA:   r = mk_res(K_SEND, c.dbyte, 1'b1);
      SEQ_DATA_END: begin
        case (s)
          3'd0:    r = mk_res(K_SEND, c.dbyte, 1'b0);
          3'd1:    r = mk_res(K_REL, 8'd0, 1'b0);
          3'd2:    r = mk_res(K_SEND, OP_RDSR, 1'b0);
          default: r = mk_res(K_RECV, 8'd0, 1'b1);
        endcase
      end
      SEQ_HOST_MORE: begin
        if (s == 3'd0) r = mk_res(K_HOST, c.dbyte, 1'b0);
        else           r = mk_res(K_RECV, 8'd0, 1'b1);
      end
      SEQ_HOST_END: begin
        case (s)
          3'd0:    r = mk_res(K_HOST, c.dbyte, 1'b0);
          3'd1:    r = mk_res(K_REL, 8'd0, 1'b0);
          default: r = mk_res(K_DONE, 8'd0, 1'b1);
        endcase
      end
      SEQ_POLL_BUSY: begin
        case (s)
          3'd0:    r = mk_res(K_REL, 8'd0, 1'b0);
          3'd1:    r = mk_res(K_SEND, OP_RDSR, 1'b0);
          default: r = mk_res(K_RECV, 8'd0, 1'b1);
        endcase
      end
      SEQ_POLL_CHUNK: begin
        if (s == 3'd0) r = mk_res(K_REL, 8'd0, 1'b0);
        else           r = chunk_res(c.addr, s1);
      end
      SEQ_POLL_FINISH: begin
        if (s == 3'd0) r = mk_res(K_REL, 8'd0, 1'b0);
        else           r = finish_res(s1);
      end
      default: r = mk_res(K_DONE, 8'd0, 1'b1);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/spiee_front.sv
// Front end: accepts requests, checks them against the phase, tracks address and counts.
`default_nettype none
module spiee_front import spiee_pkg::*; #(
  parameter int PAGE_BYTES = 256,
  parameter int MAX_LENGTH = 131072
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_data,
  input  wire logic              in_fire,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [ADDR_W-1:0] in_address,
  input  wire logic [LEN_W-1:0]  in_length,
  input  wire logic [7:0]        in_data_byte,
  output cmd_t                   push_cmd
);

  // page counter holds up to PAGE_BYTES (a power of two)
  localparam int PW = $clog2(PAGE_BYTES) + 1;

  phase_t            phase_r, phase_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [LEN_W-1:0]  total_r, total_nxt;
  logic [PW-1:0]     page_r, page_nxt;
  logic              ready_r;

  logic [LEN_W-1:0]  len_c;
  logic [LEN_W-1:0]  total_dec;
  logic [PW-1:0]     page_dec;
  logic [ADDR_W-1:0] addr_inc;
  logic [PW-1:0]     page_new_req;
  logic [PW-1:0]     page_new_cur;
  logic              out_of_order;
  req_t              req;

  // Bytes to the end of the page, capped by the bytes still to go
  function automatic logic [PW-1:0] chunk_len(logic [ADDR_W-1:0] a, logic [LEN_W-1:0] t);
    logic [PW-1:0] room;
    logic [PW-1:0] n;
    room = PW'(PAGE_BYTES) - {1'b0, a[PW-2:0]};
    if ({{(LEN_W-PW){1'b0}}, room} < t) n = room;
    else                                n = t[PW-1:0];
    return n;
  endfunction

  assign req = req_t'(in_req_type);

  // Clamp the request length
  assign len_c = ({{(25-LEN_W){1'b0}}, in_length} > 25'(MAX_LENGTH)) ?
                 LEN_W'(MAX_LENGTH) : in_length;

  assign total_dec    = (total_r != '0) ? total_r - 1'b1 : total_r;
  assign page_dec     = (page_r != '0) ? page_r - 1'b1 : page_r;
  assign addr_inc     = addr_r + 1'b1;
  assign page_new_req = chunk_len(in_address, len_c);
  assign page_new_cur = chunk_len(addr_r, total_r);

  // Classify the request against the phase
  always_comb begin
    case (req)
      REQ_READ, REQ_WRITE: out_of_order = (phase_r != PH_IDLE);
      REQ_WDATA:           out_of_order = (phase_r != PH_WDATA);
      default:             out_of_order = (phase_r != PH_READ) && (phase_r != PH_POLL);
    endcase
  end

  // Pick the result sequence and the next state
  always_comb begin
    phase_nxt       = phase_r;
    addr_nxt        = addr_r;
    total_nxt       = total_r;
    page_nxt        = page_r;
    push_cmd.seq    = SEQ_REJECT;
    push_cmd.addr   = addr_r;
    push_cmd.dbyte  = in_data_byte;
    push_cmd.status = ST_OK;
    if (out_of_order) begin
      push_cmd.status = ST_ORDER;
    end else if ((req == REQ_READ || req == REQ_WRITE) && !ready_r) begin
      push_cmd.status = ST_NOT_READY;
    end else begin
      case (req)
        REQ_READ: begin
          addr_nxt      = in_address;
          total_nxt     = len_c;
          push_cmd.addr = in_address;
          if (len_c == '0) begin
            push_cmd.seq = SEQ_READ_ZERO;
          end else begin
            push_cmd.seq = SEQ_READ;
            phase_nxt    = PH_READ;
          end
        end
        REQ_WRITE: begin
          addr_nxt      = in_address;
          total_nxt     = len_c;
          push_cmd.addr = in_address;
          if (len_c == '0) begin
            push_cmd.seq = SEQ_FINISH;
          end else begin
            push_cmd.seq = SEQ_CHUNK;
            page_nxt     = page_new_req;
            phase_nxt    = PH_WDATA;
          end
        end
        REQ_WDATA: begin
          addr_nxt  = addr_inc;
          total_nxt = total_dec;
          page_nxt  = page_dec;
          if (page_dec == '0) begin
            push_cmd.seq = SEQ_DATA_END;
            phase_nxt    = PH_POLL;
          end else begin
            push_cmd.seq = SEQ_DATA;
          end
        end
        default: begin
          if (phase_r == PH_READ) begin
            addr_nxt  = addr_inc;
            total_nxt = total_dec;
            if (total_dec != '0) begin
              push_cmd.seq = SEQ_HOST_MORE;
            end else begin
              push_cmd.seq = SEQ_HOST_END;
              phase_nxt    = PH_IDLE;
            end
          end else if (in_data_byte[0]) begin
            push_cmd.seq = SEQ_POLL_BUSY;
          end else if (total_r != '0) begin
            push_cmd.seq = SEQ_POLL_CHUNK;
            page_nxt     = page_new_cur;
            phase_nxt    = PH_WDATA;
          end else begin
            push_cmd.seq = SEQ_POLL_FINISH;
            phase_nxt    = PH_IDLE;
          end
        end
      endcase
    end
  end

  // Hold state; advance on an accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      addr_r  <= '0;
      total_r <= '0;
      page_r  <= '0;
      ready_r <= 1'b0;
    end else begin
      if (cfg_we) ready_r <= cfg_data;
      if (in_fire) begin
        phase_r <= phase_nxt;
        addr_r  <= addr_nxt;
        total_r <= total_nxt;
        page_r  <= page_nxt;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/spiee_queue.sv
// Short command queue between front and back ends.
`default_nettype none
module spiee_queue import spiee_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      pop_valid,
  output cmd_t      pop_cmd
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;

  assign full      = (count_r == (QPTR_W+1)'(QDEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/spiee_back.sv
// Back end: expands each queued command into its result requests, one per cycle while out_stall is low.
`default_nettype none
module spiee_back import spiee_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  wire cmd_t  q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_value,
  output logic [1:0] out_status,
  output logic       out_last
);

  cmd_t       cur_r;
  logic       cur_valid_r, cur_valid_nxt;
  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_r;
  res_t       res;
  logic       adv;
  logic       cmd_done;

  assign res      = cmd_result(cur_r, step_r);
  assign adv      = cur_valid_r && (!out_valid_r || !out_stall);
  assign cmd_done = adv && res.last;
  assign q_pop    = q_valid && (!cur_valid_r || cmd_done);

  // Step through the command; take the next one when it ends
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (cmd_done) cur_valid_nxt = 1'b0;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      step_nxt      = '0;
    end else if (adv) begin
      step_nxt = step_r + 1'b1;
    end
    if (adv)             out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load command and output payloads
  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_cmd;
    if (adv)   out_r <= res;
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_r.kind;
  assign out_value  = out_r.value;
  assign out_status = out_r.status;
  assign out_last   = out_r.last;

endmodule
`default_nettype wire

>>> hw/rtl/spi_eeprom_page_write_sequencer.sv
// Top level of the SPI EEPROM page write sequencer.
// Input channel (in_valid / in_stall): read and write requests, write data
// bytes and bytes received from the serial link. A request is taken at each
// edge with in_valid high and in_stall low; in_stall rises only when the
// four-entry command queue is full.
// Output channel (out_valid / out_stall): send-byte, receive-slot, chip select
// release, host data and done requests, one per cycle, last marking the final
// result of each input request. Each input request yields 1 to 7 results.
// The first result of a request passes through the command queue, the back
// end's command register and its output register. A new request may enter each
// cycle while in_stall is low; the sustained rate is one result per cycle while
// out_stall is low, set by the back end's sequence stepper.
// Configuration (cfg_valid / cfg_ready): cfg_data sets device ready; cfg_ready
// is always high. Write it only while the block is idle.
// Reset (rst_n low, synchronous) returns the phase to idle, clears the
// address and counters, clears device ready and empties queue and output.
// While the receiver stalls, the output request holds and the queue fills,
// then in_stall rises.
// PAGE_BYTES must be a power of two.
`default_nettype none
module spi_eeprom_page_write_sequencer import spiee_pkg::*; #(
  parameter int PAGE_BYTES = 256,
  parameter int MAX_LENGTH = 131072
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [23:0] in_address,
  input  wire logic [17:0] in_length,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_value,
  output logic [1:0]       out_status,
  output logic             out_last
);

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic in_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_fire   = in_valid && !q_full;

  spiee_front #(
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid),
    .cfg_data     (cfg_data),
    .in_fire      (in_fire),
    .in_req_type  (in_req_type),
    .in_address   (in_address),
    .in_length    (in_length),
    .in_data_byte (in_data_byte),
    .push_cmd     (push_cmd)
  );

  spiee_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (pop_cmd)
  );

  spiee_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_value  (out_value),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire
